>>> hdl/rfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants for the ranging frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam logic [7:0] MAX_PAYLOAD_W = 8'(MAX_PAYLOAD);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_LIMIT = 2'd2;

	localparam logic [3:0] COUNT_LIMIT_RST = 4'd6;
	localparam logic [6:0] PAYLOAD_LIMIT_RST = 7'd64;
	localparam logic [3:0] TAIL_LIMIT_RST = 4'd4;

	localparam logic [7:0] CH_START = 8'h53;  // 'S'
	localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
	localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
	localparam logic [7:0] CH_LOWER_C = 8'h63;  // 'c'
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HDR2 = 3'd1,
		PH_CNT = 3'd2,
		PH_PAY = 3'd3,
		PH_TAIL = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_FRAMING = 2'd0,
		ROLE_COUNT = 2'd1,
		ROLE_PAYLOAD = 2'd2,
		ROLE_TAIL = 2'd3
	} role_t;

	typedef struct packed {
		logic [3:0] count_limit;
		logic [6:0] payload_limit;
		logic [3:0] tail_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		role_t byte_role;
		logic [6:0] field_index;
		logic frame_done;
		logic frame_aborted;
		logic [6:0] payload_length;
	} result_t;

endpackage

>>> hdl/ranging_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranging_frame_parser_core
// Byte-wise parser for S:<count>,<payload>c<tail>\n frames.
// ----------------------------------------------------------------------------
// One byte is taken per clock unless the output stalls, and every byte yields
// exactly one result. A byte is captured in the input register, parsed against
// the frame phase and field counters in a single step, and the result is held
// in the output register, at a sustained rate of one per cycle without stalls;
// the single phase/counter update per byte sets that rate. Limits must be
// written through the config port while the parser is idle; it is not enforced.
module ranging_frame_parser_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] echo_byte,
	output logic [1:0] byte_role,
	output logic [6:0] field_index,
	output logic frame_done,
	output logic frame_aborted,
	output logic [6:0] payload_length,
	input  logic cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rfp_pkg::*;

	cfg_t cfg;
	result_t res;
	result_t res_s2;
	logic valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	rfp_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	rfp_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.rx_byte(byte_s1),
		.cfg(cfg),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign echo_byte = res_s2.echo_byte;
	assign byte_role = res_s2.byte_role;
	assign field_index = res_s2.field_index;
	assign frame_done = res_s2.frame_done;
	assign frame_aborted = res_s2.frame_aborted;
	assign payload_length = res_s2.payload_length;

`ifndef ASSERT_OFF
	a_done_not_aborted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && frame_aborted))
		else $error("frame done and aborted together");

	a_done_framing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> byte_role == ROLE_FRAMING)
		else $error("frame done on a field byte");

	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> payload_length == 7'd0)
		else $error("payload length outside frame done");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a stalled byte");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && res_s2.echo_byte == $past(byte_s1))
		else $error("result stage did not capture parsed byte");
`endif

endmodule

>>> hdl/rfp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_cfg_regs
// Field limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module rfp_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfp_pkg::CFG_DATA_W-1:0] cfg_data,
	output rfp_pkg::cfg_t cfg
);
	import rfp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_limit <= COUNT_LIMIT_RST;
			cfg_q.payload_limit <= PAYLOAD_LIMIT_RST;
			cfg_q.tail_limit <= TAIL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNT_LIMIT: cfg_q.count_limit <= cfg_data[3:0];
				REG_PAYLOAD_LIMIT: cfg_q.payload_limit <= cfg_data;
				REG_TAIL_LIMIT: cfg_q.tail_limit <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/rfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_parser
// Frame phase and field counters; one parse step per byte.
// ----------------------------------------------------------------------------
module rfp_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] rx_byte,
	input  rfp_pkg::cfg_t cfg,
	output rfp_pkg::result_t result
);
	import rfp_pkg::*;

	phase_t phase_q, phase_d;
	logic [6:0] field_cnt_q, field_cnt_d;
	logic [6:0] pay_len_q, pay_len_d;
	logic [7:0] fld_next;
	logic [7:0] pay_next;
	logic [7:0] pay_lim;

	assign fld_next = {1'b0, field_cnt_q} + 8'd1;
	assign pay_next = {1'b0, pay_len_q} + 8'd1;
	assign pay_lim = ({1'b0, cfg.payload_limit} > MAX_PAYLOAD_W) ?
		MAX_PAYLOAD_W : {1'b0, cfg.payload_limit};

	always_comb begin
		phase_d = phase_q;
		field_cnt_d = field_cnt_q;
		pay_len_d = pay_len_q;
		result.echo_byte = rx_byte;
		result.byte_role = ROLE_FRAMING;
		result.field_index = '0;
		result.frame_done = 1'b0;
		result.frame_aborted = 1'b0;
		result.payload_length = '0;
		unique case (phase_q)
			PH_HDR2: begin
				if (rx_byte == CH_COLON) begin
					phase_d = PH_CNT;
					field_cnt_d = '0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_CNT: begin
				if (rx_byte == CH_COMMA) begin
					phase_d = PH_PAY;
					pay_len_d = '0;
				end else begin
					result.byte_role = ROLE_COUNT;
					result.field_index = field_cnt_q;
					field_cnt_d = fld_next[6:0];
					if (fld_next > {4'b0, cfg.count_limit}) begin
						result.frame_aborted = 1'b1;
						phase_d = PH_HUNT;
					end
				end
			end
			PH_PAY: begin
				if (rx_byte == CH_LOWER_C) begin
					phase_d = PH_TAIL;
					field_cnt_d = '0;
				end else begin
					result.byte_role = ROLE_PAYLOAD;
					result.field_index = pay_len_q;
					pay_len_d = pay_next[6:0];
					if (pay_next > pay_lim) begin
						result.frame_aborted = 1'b1;
						phase_d = PH_HUNT;
					end
				end
			end
			PH_TAIL: begin
				if (rx_byte == CH_NEWLINE) begin
					phase_d = PH_HUNT;
					result.frame_done = 1'b1;
					result.payload_length = pay_len_q;
				end else begin
					result.byte_role = ROLE_TAIL;
					result.field_index = field_cnt_q;
					field_cnt_d = fld_next[6:0];
					if (fld_next > {4'b0, cfg.tail_limit}) begin
						result.frame_aborted = 1'b1;
						phase_d = PH_HUNT;
					end
				end
			end
			default: begin
				phase_d = (rx_byte == CH_START) ? PH_HDR2 : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			field_cnt_q <= '0;
			pay_len_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			field_cnt_q <= field_cnt_d;
			pay_len_q <= pay_len_d;
		end
	end

endmodule

>>> tb/tb_ranging_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ranging_frame_parser_core
// Self-checking bench for the byte-wise ranging frame parser.
// ----------------------------------------------------------------------------
// Bytes go in over a valid/ready request channel and every accepted byte is
// run through a local frame tracker that yields the expected result. Results
// are checked in order, field by field. Directed frames cover the header,
// empty fields and overruns; limit tests hit zero and maximum limits; random
// phases send mostly well-formed frames with random content, plus noise and
// broken frames, under several limit settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_ranging_frame_parser_core;

	import rfp_pkg::*;

	localparam int RANDOM_BYTES = 1350;
	localparam int DRAIN_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_ready;
	logic [7:0] echo_byte;
	logic [1:0] byte_role;
	logic [6:0] field_index;
	logic frame_done;
	logic frame_aborted;
	logic [6:0] payload_length;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// frame tracker state and limits
	phase_t trk_phase;
	logic [6:0] trk_field_cnt;
	logic [6:0] trk_pay_cnt;
	logic [3:0] lim_count;
	logic [6:0] lim_payload;
	logic [3:0] lim_tail;

	result_t parsed_q[$];
	int fail_cnt;
	int bytes_sent;
	bit gaps_on;

	ranging_frame_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.echo_byte(echo_byte),
		.byte_role(byte_role),
		.field_index(field_index),
		.frame_done(frame_done),
		.frame_aborted(frame_aborted),
		.payload_length(payload_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic result_t track_byte(input logic [7:0] c);
		result_t r;
		int nxt;
		int lim;
		r = '0;
		r.echo_byte = c;
		r.byte_role = ROLE_FRAMING;
		case (trk_phase)
			PH_HDR2: begin
				if (c == CH_COLON) begin
					trk_phase = PH_CNT;
					trk_field_cnt = '0;
				end else begin
					trk_phase = PH_HUNT;
				end
			end
			PH_CNT: begin
				if (c == CH_COMMA) begin
					trk_phase = PH_PAY;
					trk_pay_cnt = '0;
				end else begin
					r.byte_role = ROLE_COUNT;
					r.field_index = trk_field_cnt;
					nxt = int'(trk_field_cnt) + 1;
					trk_field_cnt = 7'(nxt);
					if (nxt > int'(lim_count)) begin
						r.frame_aborted = 1'b1;
						trk_phase = PH_HUNT;
					end
				end
			end
			PH_PAY: begin
				if (c == CH_LOWER_C) begin
					trk_phase = PH_TAIL;
					trk_field_cnt = '0;
				end else begin
					r.byte_role = ROLE_PAYLOAD;
					r.field_index = trk_pay_cnt;
					nxt = int'(trk_pay_cnt) + 1;
					trk_pay_cnt = 7'(nxt);
					lim = (int'(lim_payload) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(lim_payload);
					if (nxt > lim) begin
						r.frame_aborted = 1'b1;
						trk_phase = PH_HUNT;
					end
				end
			end
			PH_TAIL: begin
				if (c == CH_NEWLINE) begin
					trk_phase = PH_HUNT;
					r.frame_done = 1'b1;
					r.payload_length = trk_pay_cnt;
				end else begin
					r.byte_role = ROLE_TAIL;
					r.field_index = trk_field_cnt;
					nxt = int'(trk_field_cnt) + 1;
					trk_field_cnt = 7'(nxt);
					if (nxt > int'(lim_tail)) begin
						r.frame_aborted = 1'b1;
						trk_phase = PH_HUNT;
					end
				end
			end
			default: begin
				trk_phase = (c == CH_START) ? PH_HDR2 : PH_HUNT;
			end
		endcase
		return r;
	endfunction

	// one request; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
		parsed_q.push_back(track_byte(b));
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain_results();
		int n;
		n = 0;
		in_valid = 1'b0;
		while (parsed_q.size() > 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_COUNT_LIMIT: lim_count = data[3:0];
			REG_PAYLOAD_LIMIT: lim_payload = data;
			REG_TAIL_LIMIT: lim_tail = data[3:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [6:0] c, input logic [6:0] p, input logic [6:0] t);
		drain_results();
		write_reg(REG_COUNT_LIMIT, c);
		write_reg(REG_PAYLOAD_LIMIT, p);
		write_reg(REG_TAIL_LIMIT, t);
	endtask

	function automatic logic [7:0] byte_other_than(input logic [7:0] x);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == x);
		return v;
	endfunction

	function automatic int field_len(input int lim);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return lim + 1;
		if (r < 14)
			return $urandom_range(0, (lim < 6) ? lim : 6);
		return $urandom_range(0, lim);
	endfunction

	task automatic send_random_frame();
		int r;
		int plim;
		r = $urandom_range(0, 11);
		plim = (int'(lim_payload) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(lim_payload);
		if (r == 0) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		send_byte(CH_START);
		if (r == 1) begin
			send_byte(byte_other_than(CH_COLON));
			return;
		end
		send_byte(CH_COLON);
		repeat (field_len(int'(lim_count))) send_byte(byte_other_than(CH_COMMA));
		if (r == 2)
			return;
		send_byte(CH_COMMA);
		repeat (field_len(plim)) send_byte(byte_other_than(CH_LOWER_C));
		if (r == 3)
			return;
		send_byte(CH_LOWER_C);
		repeat (field_len(int'(lim_tail))) send_byte(byte_other_than(CH_NEWLINE));
		send_byte(CH_NEWLINE);
	endtask

	// reset limits: repeated start byte, empty fields, extreme bytes, count overrun
	task automatic test_directed_frames();
		send_text("SS:");
		send_text("S:9,");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_LOWER_C);
		send_byte(8'h80);
		send_byte(CH_NEWLINE);
		send_text("S:,c\n");
		send_text("S:0123456");
	endtask

	task automatic test_limit_extremes();
		set_limits(7'd0, 7'd0, 7'd0);
		send_text("S:a");
		send_text("S:,b");
		send_text("S:,cx");
		send_text("S:,c\n");
		// upper bits of the 4-bit limits are dropped; payload clamps to MAX_PAYLOAD
		set_limits(7'h7F, 7'd127, 7'h7F);
		send_text("S:");
		repeat (15) send_byte(byte_other_than(CH_COMMA));
		send_byte(CH_COMMA);
		repeat (MAX_PAYLOAD) send_byte(byte_other_than(CH_LOWER_C));
		send_byte(CH_LOWER_C);
		repeat (15) send_byte(byte_other_than(CH_NEWLINE));
		send_byte(CH_NEWLINE);
		send_text("S:");
		repeat (16) send_byte(byte_other_than(CH_COMMA));
		send_text("S:,");
		repeat (MAX_PAYLOAD + 1) send_byte(byte_other_than(CH_LOWER_C));
		send_text("S:,c");
		repeat (16) send_byte(byte_other_than(CH_NEWLINE));
		set_limits(7'd1, 7'd1, 7'd1);
		send_text("S:ab");
		send_text("S:a,bc");
		send_text("S:a,bcde");
		send_text("S:a,bcd\n");
	endtask

	task automatic test_random_traffic();
		int setting;
		int phase_start;
		setting = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			case (setting)
				0: set_limits(7'd6, 7'd64, 7'd4);
				1: set_limits(7'd15, 7'd127, 7'd15);
				2: set_limits(7'd1, 7'd1, 7'd1);
				3: set_limits(7'd3, 7'd8, 7'd2);
				default: set_limits(7'($urandom_range(1, 15)), 7'($urandom_range(1, 127)),
					7'($urandom_range(1, 15)));
			endcase
			// every fourth phase runs without gaps or stalls
			gaps_on = (setting % 4) != 3;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 180 && bytes_sent < RANDOM_BYTES) begin
				send_random_frame();
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
			setting++;
		end
		gaps_on = 1'b1;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (parsed_q.size() == 0) begin
				$error("result with no request pending, echo_byte %0d", echo_byte);
				fail_cnt++;
			end else begin
				e = parsed_q.pop_front();
				check_field("echo_byte", int'(e.echo_byte), int'(echo_byte));
				check_field("byte_role", int'(e.byte_role), int'(byte_role));
				check_field("field_index", int'(e.field_index), int'(field_index));
				check_field("frame_done", int'(e.frame_done), int'(frame_done));
				check_field("frame_aborted", int'(e.frame_aborted), int'(frame_aborted));
				check_field("payload_length", int'(e.payload_length),
					int'(payload_length));
			end
		end
	end

	initial begin : result_sink
		int stall;
		stall = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		fail_cnt = 0;
		bytes_sent = 0;
		gaps_on = 1'b1;
		trk_phase = PH_HUNT;
		trk_field_cnt = '0;
		trk_pay_cnt = '0;
		lim_count = COUNT_LIMIT_RST;
		lim_payload = PAYLOAD_LIMIT_RST;
		lim_tail = TAIL_LIMIT_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_limit_extremes();
		test_random_traffic();

		drain_results();
		if (parsed_q.size() > 0) begin
			$error("%0d results never arrived", parsed_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
